// File: sv/rcfp_pkg.sv
// Shared types, codes and constants of the relay command frame parser.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rcfp_pkg;

  localparam int RELAY_COUNT_DEFAULT = 3;
  localparam int OUT_RELAY_W = 3;

  localparam logic [7:0] FRAME_PREFIX  = 8'hA0;
  localparam logic [7:0] CMD_SET_LEVEL = 8'hFE;
  localparam logic [7:0] CMD_ALL       = 8'hFF;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_TARGET = 2'd1,
    PH_SWITCH = 2'd2,
    PH_SUM    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_TAKEN      = 3'd0,
    ST_APPLIED    = 3'd1,
    ST_BAD_PREFIX = 3'd2,
    ST_BAD_RELAY  = 3'd3,
    ST_BAD_ONOFF  = 3'd4,
    ST_BAD_SUM    = 3'd5
  } status_t;

  typedef struct packed {
    logic [OUT_RELAY_W-1:0] relay_drive;
    logic [OUT_RELAY_W-1:0] relay_on;
    logic                   level_now;
    status_t                status;
  } result_t;

endpackage

// File: sv/rcfp_if.sv
// Valid/ready channel interfaces for received bytes and for per-byte results.
// Depends on rcfp_pkg for the result field widths.
`timescale 1ns / 1ps

interface rcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [rcfp_pkg::OUT_RELAY_W-1:0] relay_drive;
  logic [rcfp_pkg::OUT_RELAY_W-1:0] relay_on;
  logic                            level_now;
  logic [2:0]                      status;

  modport source (output valid, output relay_drive, output relay_on, output level_now,
                  output status, input ready);
  modport sink (input valid, input relay_drive, input relay_on, input level_now,
                input status, output ready);
endinterface

// File: sv/relay_command_frame_parser_top.sv
// Each result is registered on acceptance; one byte per cycle is taken while the buffer has space.
// The parser step is a single register-to-register pass; a two-entry result buffer keeps
// input ready high while one result waits, so bytes stream back to back while the consumer
// keeps up. Under a longer output stall the input stops once two results are waiting.
// Reset (rst, synchronous, active high) restarts parsing at the prefix, turns all relays off,
// selects active-high drive, sets the first relay number to one and empties the result buffer.
`timescale 1ns / 1ps

// Top level of the relay command frame parser.
// Each accepted byte transaction advances the four-byte frame parser by one step and
// produces exactly one result transaction: relay pin levels, logical relay states,
// the active drive level and a status code. Frames are prefix, target, on/off value
// and an 8-bit sum checksum of the first three bytes. A target of all ones switches
// every relay; the target just below it sets the drive level and turns all relays off.
// The configuration register holds the number that addresses relay zero in frames.
module relay_command_frame_parser_top #(
  parameter int RELAY_COUNT = rcfp_pkg::RELAY_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rcfp_in_if.sink     rx,
  rcfp_out_if.source  resp
);

  // A byte is accepted whenever the result buffer has a free entry.
  logic              in_fire;
  logic              space;
  rcfp_pkg::result_t step_result;

  assign rx.ready = space;
  assign in_fire  = rx.valid && rx.ready;

  // The parser holds all frame state and computes the result from the incoming byte.
  rcfp_parser #(
    .RELAY_COUNT (RELAY_COUNT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .rx_byte   (rx.rx_byte),
    .result    (step_result)
  );

  // The buffer registers each result and presents it until the consumer takes it.
  rcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (step_result),
    .space     (space),
    .resp      (resp)
  );

endmodule

// File: sv/rcfp_parser.sv
// Frame parser: parse phase, held frame fields, relay states, drive level and config.
// Depends on rcfp_pkg; computes one result per accepted byte.
`timescale 1ns / 1ps

module rcfp_parser #(
  parameter int RELAY_COUNT = rcfp_pkg::RELAY_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output rcfp_pkg::result_t result
);

  rcfp_pkg::phase_t       phase, phase_next;
  logic                   first_relay;
  logic [7:0]             held_target, held_target_next;
  logic                   held_switch, held_switch_next;
  logic [RELAY_COUNT-1:0] relay_states, relay_states_next;
  logic                   drive_level, drive_level_next;
  rcfp_pkg::status_t      status;

  logic [7:0]             checksum;
  logic [7:0]             held_offset;
  logic [RELAY_COUNT-1:0] held_bit;
  logic                   byte_target_ok;
  logic                   held_target_ok;
  logic [RELAY_COUNT-1:0] drive_full;

  function automatic logic target_ok(input logic [7:0] t, input logic frn);
    logic [7:0] offs;
    offs = t - {7'd0, frn};
    return (t == rcfp_pkg::CMD_ALL) || (t == rcfp_pkg::CMD_SET_LEVEL) ||
           ((t >= {7'd0, frn}) && (offs < 8'(RELAY_COUNT)));
  endfunction

  assign byte_target_ok = target_ok(rx_byte, first_relay);
  assign held_target_ok = target_ok(held_target, first_relay);
  assign checksum       = rcfp_pkg::FRAME_PREFIX + held_target + {7'd0, held_switch};
  assign held_offset    = held_target - {7'd0, first_relay};

  always_comb begin
    for (int i = 0; i < RELAY_COUNT; i++) begin
      held_bit[i] = (held_offset[2:0] == 3'(i));
    end
  end

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      rcfp_pkg::PH_PREFIX: begin
        if (rx_byte == rcfp_pkg::FRAME_PREFIX) phase_next = rcfp_pkg::PH_TARGET;
      end
      rcfp_pkg::PH_TARGET: begin
        phase_next = byte_target_ok ? rcfp_pkg::PH_SWITCH : rcfp_pkg::PH_PREFIX;
      end
      rcfp_pkg::PH_SWITCH: begin
        phase_next = (rx_byte <= 8'd1) ? rcfp_pkg::PH_SUM : rcfp_pkg::PH_PREFIX;
      end
      rcfp_pkg::PH_SUM: begin
        phase_next = rcfp_pkg::PH_PREFIX;
      end
    endcase
  end

  // Held fields, relay updates and status for the byte at the input.
  always_comb begin
    held_target_next  = held_target;
    held_switch_next  = held_switch;
    relay_states_next = relay_states;
    drive_level_next  = drive_level;
    status            = rcfp_pkg::ST_TAKEN;
    unique case (phase)
      rcfp_pkg::PH_PREFIX: begin
        if (rx_byte != rcfp_pkg::FRAME_PREFIX) status = rcfp_pkg::ST_BAD_PREFIX;
      end
      rcfp_pkg::PH_TARGET: begin
        if (byte_target_ok) held_target_next = rx_byte;
        else status = rcfp_pkg::ST_BAD_RELAY;
      end
      rcfp_pkg::PH_SWITCH: begin
        if (rx_byte <= 8'd1) held_switch_next = rx_byte[0];
        else status = rcfp_pkg::ST_BAD_ONOFF;
      end
      rcfp_pkg::PH_SUM: begin
        if (rx_byte != checksum) begin
          status = rcfp_pkg::ST_BAD_SUM;
        end else if (!held_target_ok) begin
          // The base relay number may have moved since the target byte arrived.
          status = rcfp_pkg::ST_BAD_RELAY;
        end else begin
          status = rcfp_pkg::ST_APPLIED;
          if (held_target == rcfp_pkg::CMD_ALL) begin
            relay_states_next = held_switch ? '1 : '0;
          end else if (held_target == rcfp_pkg::CMD_SET_LEVEL) begin
            drive_level_next  = held_switch;
            relay_states_next = '0;
          end else if (held_switch) begin
            relay_states_next = relay_states | held_bit;
          end else begin
            relay_states_next = relay_states & ~held_bit;
          end
        end
      end
    endcase
  end

  assign drive_full = drive_level_next ? relay_states_next : ~relay_states_next;

  // Relays beyond the visible output width are dropped; unused bits read as zero.
  always_comb begin
    result.relay_drive = '0;
    result.relay_on    = '0;
    for (int i = 0; i < rcfp_pkg::OUT_RELAY_W; i++) begin
      if (i < RELAY_COUNT) begin
        result.relay_drive[i] = drive_full[i % RELAY_COUNT];
        result.relay_on[i]    = relay_states_next[i % RELAY_COUNT];
      end
    end
    result.level_now = drive_level_next;
    result.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= rcfp_pkg::PH_PREFIX;
      first_relay  <= 1'b1;
      held_target  <= 8'd0;
      held_switch  <= 1'b0;
      relay_states <= '0;
      drive_level  <= 1'b1;
    end else begin
      if (cfg_we) first_relay <= cfg_wdata;
      if (in_fire) begin
        phase        <= phase_next;
        held_target  <= held_target_next;
        held_switch  <= held_switch_next;
        relay_states <= relay_states_next;
        drive_level  <= drive_level_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_returns_to_prefix: assert property (@(posedge clk) disable iff (rst)
    in_fire && (phase == rcfp_pkg::PH_SUM) |=> phase == rcfp_pkg::PH_PREFIX)
    else $error("parser did not restart after checksum byte");
  a_reject_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && (status != rcfp_pkg::ST_TAKEN) |=> phase == rcfp_pkg::PH_PREFIX)
    else $error("parser did not restart after rejected byte or applied frame");
  a_relays_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(relay_states) && $stable(drive_level))
    else $error("relay state changed without an accepted byte");
`endif

endmodule

// File: sv/rcfp_out_buf.sv
// Two-entry result buffer that decouples the parser from a stalling consumer.
// Depends on rcfp_pkg for the result type and on rcfp_out_if for the output channel.
`timescale 1ns / 1ps

module rcfp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rcfp_pkg::result_t push_data,
  output logic              space,
  rcfp_out_if.source        resp
);

  rcfp_pkg::result_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;
  rcfp_pkg::result_t head;

  assign pop   = resp.valid && resp.ready;
  assign space = (count != 2'd2);
  assign head  = entries[rd_ptr];

  assign resp.valid       = (count != 2'd0);
  assign resp.relay_drive = head.relay_drive;
  assign resp.relay_on    = head.relay_on;
  assign resp.level_now   = head.level_now;
  assign resp.status      = head.status;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result buffer overflow");
  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("result buffer lost an entry");
  a_pop_only_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1)
    else $error("result buffer count wrong after pop");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for the relay command frame parser: a queue-fed byte driver, a result
// monitor with random back-pressure, and a cycle-free model of the parser state.
// Depends on rcfp_pkg, the rcfp_in_if/rcfp_out_if interfaces and relay_command_frame_parser_top.
`timescale 1ns / 1ps

module testbench;

  localparam int RELAYS_USED = rcfp_pkg::RELAY_COUNT_DEFAULT;
  localparam logic [2:0] RELAY_MASK = 3'((1 << RELAYS_USED) - 1);
  // Bytes queued per random phase; six phases give roughly the wanted volume.
  localparam int PHASE_BYTES = 275;
  localparam int NUM_RANDOM_PHASES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  rcfp_in_if  rx_ch ();
  rcfp_out_if resp_ch ();

  relay_command_frame_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .resp      (resp_ch)
  );

  always #2 clk = ~clk;

  // Both handshake inputs of the block must be known from time zero.
  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    resp_ch.ready = 1'b0;
  end

  // Bytes waiting to be sent, and the results the parser owes for bytes already accepted.
  logic [7:0]        byte_q[$];
  rcfp_pkg::result_t expected_results[$];
  int                fails = 0;

  // Shadow copy of the parser state and of the first-relay-number register.
  rcfp_pkg::phase_t sh_phase  = rcfp_pkg::PH_PREFIX;
  logic [7:0]       sh_target = 8'h00;
  logic             sh_switch = 1'b0;
  logic [2:0]       sh_relays = 3'b000;
  logic             sh_level  = 1'b1;
  logic             sh_first  = 1'b1;

  // A target is legal if it is one of the two broadcast commands or addresses a real relay
  // under the current numbering.
  function automatic bit target_legal(logic [7:0] t);
    if (t == rcfp_pkg::CMD_ALL || t == rcfp_pkg::CMD_SET_LEVEL) return 1'b1;
    return (int'(t) >= int'(sh_first)) && (int'(t) - int'(sh_first) < RELAYS_USED);
  endfunction

  // Advances the shadow parser by one byte and returns the result the block must produce.
  function automatic rcfp_pkg::result_t parse_step(logic [7:0] b);
    rcfp_pkg::result_t res;
    rcfp_pkg::status_t st;
    logic [2:0]        sel;
    st = rcfp_pkg::ST_TAKEN;
    case (sh_phase)
      rcfp_pkg::PH_PREFIX: begin
        if (b == rcfp_pkg::FRAME_PREFIX) sh_phase = rcfp_pkg::PH_TARGET;
        else st = rcfp_pkg::ST_BAD_PREFIX;
      end
      rcfp_pkg::PH_TARGET: begin
        if (target_legal(b)) begin
          sh_target = b;
          sh_phase  = rcfp_pkg::PH_SWITCH;
        end else begin
          st       = rcfp_pkg::ST_BAD_RELAY;
          sh_phase = rcfp_pkg::PH_PREFIX;
        end
      end
      rcfp_pkg::PH_SWITCH: begin
        if (b <= 8'd1) begin
          sh_switch = b[0];
          sh_phase  = rcfp_pkg::PH_SUM;
        end else begin
          st       = rcfp_pkg::ST_BAD_ONOFF;
          sh_phase = rcfp_pkg::PH_PREFIX;
        end
      end
      default: begin
        sh_phase = rcfp_pkg::PH_PREFIX;
        if (b != 8'(rcfp_pkg::FRAME_PREFIX + sh_target + {7'b0, sh_switch})) begin
          st = rcfp_pkg::ST_BAD_SUM;
        end else if (!target_legal(sh_target)) begin
          // The numbering may have changed since the target byte was taken.
          st = rcfp_pkg::ST_BAD_RELAY;
        end else begin
          st = rcfp_pkg::ST_APPLIED;
          if (sh_target == rcfp_pkg::CMD_ALL) begin
            sh_relays = sh_switch ? RELAY_MASK : 3'b000;
          end else if (sh_target == rcfp_pkg::CMD_SET_LEVEL) begin
            sh_level  = sh_switch;
            sh_relays = 3'b000;
          end else begin
            sel = 3'(sh_target - {7'b0, sh_first});
            sh_relays[sel] = sh_switch;
          end
        end
      end
    endcase
    sh_relays       = sh_relays & RELAY_MASK;
    res.relay_on    = sh_relays;
    res.relay_drive = sh_level ? sh_relays : (~sh_relays & RELAY_MASK);
    res.level_now   = sh_level;
    res.status      = st;
    return res;
  endfunction

  // Idle length between transactions: mostly none or short, a few long, and now and then a
  // calm stretch of back-to-back transactions.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 50);
  endfunction

  // Byte driver. The expectation is computed at the edge where the byte is accepted, and
  // the next byte (or an idle cycle) is presented only when the slot is free.
  int send_gap = 0;
  int send_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) expected_results.push_back(parse_step(rx_ch.rx_byte));
      if (!rx_ch.valid || rx_ch.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          rx_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          rx_ch.rx_byte <= byte_q.pop_front();
          rx_ch.valid   <= 1'b1;
          send_gap      <= pick_gap(send_calm);
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fails++;
    end
  endtask

  // Result monitor. Every accepted result transaction is matched against the oldest
  // expectation; after each one, ready may be dropped for a random stall.
  int stall_left = 0;
  int recv_calm = 0;
  rcfp_pkg::result_t oldest;
  always @(posedge clk) begin
    if (rst) begin
      resp_ch.ready <= 1'b0;
    end else begin
      if (resp_ch.valid && resp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time, resp_ch.status);
          fails++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("relay_drive", 8'(oldest.relay_drive), 8'(resp_ch.relay_drive));
          check_field("relay_on", 8'(oldest.relay_on), 8'(resp_ch.relay_on));
          check_field("level_now", 8'(oldest.level_now), 8'(resp_ch.level_now));
          check_field("status", 8'(oldest.status), 8'(resp_ch.status));
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        resp_ch.ready <= 1'b0;
      end else begin
        resp_ch.ready <= 1'b1;
        if (resp_ch.valid && resp_ch.ready) stall_left <= pick_gap(recv_calm);
      end
    end
  end

  task automatic push_frame(logic [7:0] t, logic [7:0] sw);
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);
    byte_q.push_back(t);
    byte_q.push_back(sw);
    byte_q.push_back(8'(rcfp_pkg::FRAME_PREFIX + t + sw));
  endtask

  // Blocks until every queued byte has been sent and every result has come back, then
  // waits on so that the block is truly quiet.
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_q.size() != 0 || rx_ch.valid || expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Register write, only ever issued while the block is idle.
  task automatic write_first(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_first = v;
  endtask

  initial begin
    int         queued;
    int         kind;
    int         sel;
    int         n;
    logic [7:0] tgt;
    logic [7:0] sw;
    logic [7:0] sum;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset numbering (relay zero is addressed as one).
    push_frame(8'h01, 8'h01);                     // single relay on
    push_frame(rcfp_pkg::CMD_ALL, 8'h01);         // every relay on
    push_frame(rcfp_pkg::CMD_SET_LEVEL, 8'h00);   // active-low drive, all relays off
    push_frame(8'h03, 8'h01);                     // last relay on, seen inverted on its pin
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);     // relay number just past the last relay
    byte_q.push_back(8'h04);
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);     // prefix arriving where the target belongs
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);
    byte_q.push_back(8'hFF);                      // garbage where a prefix is expected
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);     // on/off byte out of range
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h02);
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);     // checksum wrong
    byte_q.push_back(8'h02);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h00);
    // Renumbering inside a frame: the target was legal when it arrived but is not by the
    // time its checksum comes in.
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);
    byte_q.push_back(8'h03);
    wait_idle();
    write_first(1'b0);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'hA4);
    push_frame(8'h00, 8'h01);                     // relay zero under zero-based numbering
    push_frame(rcfp_pkg::CMD_SET_LEVEL, 8'h01);   // back to active-high drive
    byte_q.push_back(rcfp_pkg::FRAME_PREFIX);     // same renumbering case the other way round
    byte_q.push_back(8'h00);
    wait_idle();
    write_first(1'b1);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'hA1);
    wait_idle();

    // Random phases, alternating the numbering. Most traffic is well-formed frames with
    // random content; the rest is noise, corrupted checksums and truncated frames.
    for (int p = 0; p < NUM_RANDOM_PHASES; p++) begin
      write_first(logic'(p % 2));
      queued = 0;
      while (queued < PHASE_BYTES) begin
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            byte_q.push_back(($urandom_range(0, 3) == 0) ? rcfp_pkg::FRAME_PREFIX
                                                         : 8'($urandom_range(0, 255)));
          end
          queued += n;
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 45) tgt = 8'(sh_first + $urandom_range(0, RELAYS_USED - 1));
          else if (sel < 60) tgt = rcfp_pkg::CMD_ALL;
          else if (sel < 70) tgt = rcfp_pkg::CMD_SET_LEVEL;
          else if (sel < 80) tgt = 8'($urandom_range(0, 255));
          else if (sel < 90) tgt = $urandom_range(0, 1) ? 8'(sh_first + RELAYS_USED)
                                                         : 8'(sh_first) - 8'd1;
          else tgt = rcfp_pkg::FRAME_PREFIX;
          sw = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(0, 255));
          sum = 8'(rcfp_pkg::FRAME_PREFIX + tgt + sw);
          sel = $urandom_range(0, 99);
          if (sel < 8) sum = sum ^ 8'(1 << $urandom_range(0, 7));
          byte_q.push_back(rcfp_pkg::FRAME_PREFIX);
          byte_q.push_back(tgt);
          byte_q.push_back(sw);
          if (sel >= 8 && sel < 12) begin
            // Truncated: the next frame's prefix lands in the checksum slot.
            queued += 3;
          end else begin
            byte_q.push_back(sum);
            queued += 4;
          end
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
